// ----- src/e2q_pkg.sv -----
`default_nettype none
package e2q_pkg;

  localparam int TABLE_LEN = 24;
  localparam logic signed [16:0] ANG_LIMIT = 17'sd46080;
  localparam logic signed [31:0] DEG90 = 32'sd377487360;
  localparam logic signed [31:0] DEG180 = 32'sd754974720;
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } sincos_t;

  // arctangent of 2^-i in units of 2^-22 degree
  function automatic logic signed [31:0] atan_deg22(input int i);
    logic signed [31:0] v;
    unique case (i)
      0: v = 32'sd188743680;
      1: v = 32'sd111421900;
      2: v = 32'sd58872272;
      3: v = 32'sd29884485;
      4: v = 32'sd15000234;
      5: v = 32'sd7507429;
      6: v = 32'sd3754631;
      7: v = 32'sd1877430;
      8: v = 32'sd938729;
      9: v = 32'sd469366;
      10: v = 32'sd234683;
      11: v = 32'sd117342;
      12: v = 32'sd58671;
      13: v = 32'sd29335;
      14: v = 32'sd14668;
      15: v = 32'sd7334;
      16: v = 32'sd3667;
      17: v = 32'sd1833;
      18: v = 32'sd917;
      19: v = 32'sd458;
      20: v = 32'sd229;
      21: v = 32'sd115;
      22: v = 32'sd57;
      23: v = 32'sd29;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- src/e2q_cordic_lane.sv -----
`default_nettype none
module e2q_cordic_lane #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [16:0] angle,
  output e2q_pkg::sincos_t        sc
);

  localparam int NS = (CORDIC_STAGES > e2q_pkg::TABLE_LEN) ? e2q_pkg::TABLE_LEN
                                                           : CORDIC_STAGES;

  logic signed [31:0] x_r [0:NS];
  logic signed [31:0] y_r [0:NS];
  logic signed [31:0] z_r [0:NS];
  logic               neg_r [0:NS];

  logic signed [16:0] a_cl;
  logic signed [31:0] h;
  logic signed [31:0] h_nxt;
  logic               neg_nxt;

  // clamp to +-360 degrees, halve, fold into +-90 degrees
  always_comb begin
    a_cl = angle;
    if (angle > e2q_pkg::ANG_LIMIT) a_cl = e2q_pkg::ANG_LIMIT;
    if (angle < -e2q_pkg::ANG_LIMIT) a_cl = -e2q_pkg::ANG_LIMIT;
    h = {{1{a_cl[16]}}, a_cl, 14'd0};
    h_nxt = h;
    neg_nxt = 1'b0;
    if (h > e2q_pkg::DEG90) begin
      h_nxt = h - e2q_pkg::DEG180;
      neg_nxt = 1'b1;
    end else if (h < -e2q_pkg::DEG90) begin
      h_nxt = h + e2q_pkg::DEG180;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= e2q_pkg::CORDIC_GAIN_Q30;
      y_r[0] <= 32'sd0;
      z_r[0] <= h_nxt;
      neg_r[0] <= neg_nxt;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - e2q_pkg::atan_deg22(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + e2q_pkg::atan_deg22(i);
        end
      end
    end
  end

  assign sc.c = neg_r[NS] ? -x_r[NS] : x_r[NS];
  assign sc.s = neg_r[NS] ? -y_r[NS] : y_r[NS];

endmodule
`default_nettype wire

// ----- src/e2q_merge.sv -----
`default_nettype none
module e2q_merge (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire e2q_pkg::sincos_t r,
  input  wire e2q_pkg::sincos_t p,
  input  wire e2q_pkg::sincos_t y,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z
);

  function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] pr;
    logic signed [63:0] rd;
    pr = a * b;
    rd = (pr + 64'sd536870912) >>> 30;
    return rd[31:0];
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                input logic sub);
    logic signed [65:0] s;
    logic signed [65:0] v;
    logic signed [15:0] q;
    s = sub ? ({{2{a[63]}}, a} - {{2{b[63]}}, b}) : ({{2{a[63]}}, a} + {{2{b[63]}}, b});
    v = (s + (66'sd1 <<< 44)) >>> 45;
    if (v > 66'sd32767) q = 16'sh7fff;
    else if (v < -66'sd32768) q = 16'sh8000;
    else q = v[15:0];
    return q;
  endfunction

  logic signed [31:0] cc_r, ss_r, sc_r, cs_r, cy_r, sy_r;
  logic signed [63:0] w0_r, w1_r, x0_r, x1_r, y0_r, y1_r, z0_r, z1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r <= mul30(r.c, p.c);
      ss_r <= mul30(r.s, p.s);
      sc_r <= mul30(r.s, p.c);
      cs_r <= mul30(r.c, p.s);
      cy_r <= y.c;
      sy_r <= y.s;
      w0_r <= cc_r * cy_r;
      w1_r <= ss_r * sy_r;
      x0_r <= sc_r * cy_r;
      x1_r <= cs_r * sy_r;
      y0_r <= cs_r * cy_r;
      y1_r <= sc_r * sy_r;
      z0_r <= cc_r * sy_r;
      z1_r <= ss_r * cy_r;
      quat_w <= to_q15(w0_r, w1_r, 1'b0);
      quat_x <= to_q15(x0_r, x1_r, 1'b1);
      quat_y <= to_q15(y0_r, y1_r, 1'b0);
      quat_z <= to_q15(z0_r, z1_r, 1'b1);
    end
  end

endmodule
`default_nettype wire

// ----- src/euler_to_quaternion.sv -----
// throughput: one item per cycle while no result waits on out_tready, set by the fully pipelined cordic lanes
// and the two-stage multiplier tree in the merge
// reset: rst_n synchronous active low clears the valid pipe only
`default_nettype none
module euler_to_quaternion #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle, zero fill
  input  wire logic [151:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // quat_w, quat_x, quat_y, quat_z, out_pos_x, out_pos_y, out_pos_z
  output logic [159:0]      out_tdata
);

  localparam int NS = (CORDIC_STAGES > e2q_pkg::TABLE_LEN) ? e2q_pkg::TABLE_LEN
                                                           : CORDIC_STAGES;
  // fold register, cordic stages, two multiply stages, output register
  localparam int LAT = NS + 4;

  logic en;
  logic vld_r [0:LAT-1];
  logic [95:0] pos_r [0:LAT-1];

  e2q_pkg::sincos_t sc_roll, sc_pitch, sc_yaw;
  logic signed [15:0] q_w, q_x, q_y, q_z;

  // whole pipe moves unless the output holds a result not yet taken
  assign en = !(out_tvalid && !out_tready);
  assign in_tready = en;

  e2q_cordic_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .en(en), .angle(in_tdata[112:96]), .sc(sc_roll)
  );
  e2q_cordic_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .en(en), .angle(in_tdata[129:113]), .sc(sc_pitch)
  );
  e2q_cordic_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .en(en), .angle(in_tdata[146:130]), .sc(sc_yaw)
  );

  // products of the three half-angle pairs
  e2q_merge u_merge (
    .clk(clk), .en(en), .r(sc_roll), .p(sc_pitch), .y(sc_yaw),
    .quat_w(q_w), .quat_x(q_x), .quat_y(q_y), .quat_z(q_z)
  );

  // valid tracking alongside the data pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // position rides the pipe untouched
  always_ff @(posedge clk) begin
    if (en) begin
      pos_r[0] <= in_tdata[95:0];
      for (int i = 1; i < LAT; i++) pos_r[i] <= pos_r[i-1];
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {pos_r[LAT-1], q_z, q_y, q_x, q_w};

endmodule
`default_nettype wire

// ----- verif/e2q_checker.sv -----
`default_nettype none
module e2q_checker #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [151:0] in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [159:0] out_tdata,
  output int                fail_count,
  output int                pending_poses
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
    logic signed [15:0] qz;
    logic signed [15:0] qy;
    logic signed [15:0] qx;
    logic signed [15:0] qw;
  } pose_out_t;

  localparam longint ATAN_TAB [24] = '{
    188743680, 111421900, 58872272, 29884485, 15000234,
    7507429, 3754631, 1877430, 938729, 469366,
    234683, 117342, 58671, 29335, 14668,
    7334, 3667, 1833, 917, 458,
    229, 115, 57, 29
  };

  pose_out_t quat_queue [$];

  initial begin
    fail_count = 0;
  end

  assign pending_poses = quat_queue.size();

  // cos and sin of half the angle, q30
  task automatic half_trig(input logic signed [16:0] ang, output longint c,
                           output longint s);
    longint a, h, x, y, z, nx;
    int n;
    bit flip;
    a = ang;
    flip = 0;
    if (a > e2q_pkg::ANG_LIMIT) a = e2q_pkg::ANG_LIMIT;
    if (a < -e2q_pkg::ANG_LIMIT) a = -e2q_pkg::ANG_LIMIT;
    h = a * 16384;
    if (h > e2q_pkg::DEG90) begin
      h -= e2q_pkg::DEG180;
      flip = 1;
    end else if (h < -e2q_pkg::DEG90) begin
      h += e2q_pkg::DEG180;
      flip = 1;
    end
    n = (CORDIC_STAGES > e2q_pkg::TABLE_LEN) ? e2q_pkg::TABLE_LEN : CORDIC_STAGES;
    x = e2q_pkg::CORDIC_GAIN_Q30;
    y = 0;
    z = h;
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_TAB[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [15:0] sat_q15(longint q60);
    longint v;
    v = (q60 + (64'sd1 <<< 44)) >>> 45;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic predict_quat(input logic [151:0] d, output pose_out_t p);
    longint cr, sr, cp, sp, cy, sy, cc, ss, sc, cs;
    half_trig(d[112:96], cr, sr);
    half_trig(d[129:113], cp, sp);
    half_trig(d[146:130], cy, sy);
    cc = mul_q30(cr, cp);
    ss = mul_q30(sr, sp);
    sc = mul_q30(sr, cp);
    cs = mul_q30(cr, sp);
    p.qw = sat_q15(cc * cy + ss * sy);
    p.qx = sat_q15(sc * cy - cs * sy);
    p.qy = sat_q15(cs * cy + sc * sy);
    p.qz = sat_q15(cc * sy - ss * cy);
    p.pos_x = d[31:0];
    p.pos_y = d[63:32];
    p.pos_z = d[95:64];
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pose_out_t p, g;
    if (rst_n && in_tvalid && in_tready) begin
      predict_quat(in_tdata, p);
      quat_queue = {quat_queue, p};
    end
    if (rst_n && out_tvalid && out_tready) begin
      g = out_tdata;
      if (quat_queue.size() == 0) begin
        report("unexpected transfer", 0, 0);
      end else begin
        p = quat_queue.pop_front();
        if (g.qw != p.qw) report("quat_w", g.qw, p.qw);
        if (g.qx != p.qx) report("quat_x", g.qx, p.qx);
        if (g.qy != p.qy) report("quat_y", g.qy, p.qy);
        if (g.qz != p.qz) report("quat_z", g.qz, p.qz);
        if (g.pos_x != p.pos_x) report("out_pos_x", g.pos_x, p.pos_x);
        if (g.pos_y != p.pos_y) report("out_pos_y", g.pos_y, p.pos_y);
        if (g.pos_z != p.pos_z) report("out_pos_z", g.pos_z, p.pos_z);
      end
    end
  end
endmodule
`default_nettype wire

// ----- verif/tb_euler_to_quaternion.sv -----
`default_nettype none
module tb_euler_to_quaternion;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = 16;
  localparam int STALL_LIMIT = 3000;
  localparam int PER_PHASE = 340;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle, zero fill
  logic [151:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // quat_w, quat_x, quat_y, quat_z, out_pos_x, out_pos_y, out_pos_z
  logic [159:0] out_tdata;

  int fail_count;
  int pending_poses;
  int tx_idle_pct = 24;
  int rx_idle_pct = 88;
  int stall_cycles = 0;

  always #6 clk = ~clk;

  euler_to_quaternion #(.CORDIC_STAGES(STAGES)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  e2q_checker #(.CORDIC_STAGES(STAGES)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending_poses(pending_poses)
  );

  // receiver backpressure, redrawn every cycle
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one pose transfer, with random idle cycles ahead of it
  task automatic send_pose(input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] pz, input logic [16:0] roll,
                           input logic [16:0] pitch, input logic [16:0] yaw);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata <= 152'({$urandom, $urandom, $urandom, $urandom, $urandom});
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, yaw, pitch, roll, pz, py, px};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // mostly in range, some near the quadrant fold, some out of range
  function automatic logic [16:0] pick_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 17'($urandom);
    if (r == 1) return 17'($urandom_range(22900, 23200) * ($urandom_range(0, 1) ? 1 : -1));
    return 17'($signed($urandom_range(0, 92160)) - 46080);
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_pose($urandom, $urandom, $urandom,
                             pick_angle(), pick_angle(), pick_angle());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero, full turns, the fold at +-90 deg half angle
    send_pose(32'h0, 32'h0, 32'h0, 17'sd0, 17'sd0, 17'sd0);
    send_pose(32'h7fffffff, 32'h80000000, 32'hffffffff, 17'sd46080, 17'sd0, 17'sd0);
    send_pose(32'h80000000, 32'h7fffffff, 32'h1, -17'sd46080, 17'sd0, 17'sd0);
    send_pose(32'h1, 32'hffffffff, 32'h7fffffff, 17'sd0, 17'sd46080, 17'sd0);
    send_pose(32'haaaaaaaa, 32'h55555555, 32'h80000000, 17'sd0, 17'sd0, -17'sd46080);
    send_pose(32'h55555555, 32'haaaaaaaa, 32'h0, 17'sd46080, 17'sd46080, 17'sd46080);
    send_pose(32'hffffffff, 32'h0, 32'haaaaaaaa, -17'sd46080, -17'sd46080, -17'sd46080);
    send_pose(32'h12345678, 32'h0, 32'h0, 17'sd23040, 17'sd23041, -17'sd23040);
    send_pose(32'h0, 32'h12345678, 32'h0, -17'sd23041, 17'sd23039, -17'sd23039);
    send_pose(32'h0, 32'h0, 32'h12345678, 17'sd11520, 17'sd23040, 17'sd0);
    send_pose(32'h0, 32'h0, 32'h0, 17'sd0, -17'sd23040, 17'sd11520);
    // angles beyond +-360 deg are clamped
    send_pose(32'h0, 32'h0, 32'h0, 17'sd65535, 17'h10000, 17'sd46081);
    send_pose(32'h0, 32'h0, 32'h0, -17'sd46081, 17'sd50000, -17'sd60000);
    send_pose(32'h0, 32'h0, 32'h0, 17'h1ffff, 17'h10000, 17'h0ffff);
    send_pose(32'h0, 32'h0, 32'h0, 17'sd1, -17'sd1, 17'sd128);

    send_random(PER_PHASE - 15);
    tx_idle_pct = 88;
    rx_idle_pct = 24;
    send_random(PER_PHASE);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(PER_PHASE);
    in_tvalid <= 1'b0;

    while (pending_poses != 0) @(posedge clk);
    repeat (STAGES + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
